>>> hdl/snfs_pkg.sv
// snfs_pkg: shared constants, opcodes and result type of the spi nor flash sequencer
// used by the channel interfaces and by spi_nor_flash_sequencer; depends on nothing
package snfs_pkg;

  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int PAGE_BYTES_DEF   = 256;
  localparam int ADDRESS_BITS_DEF = 24;

  localparam int ACT_W     = 3;
  localparam int ADDR_W    = 24;
  localparam int LEN_W     = 25;
  localparam int BYTE_W    = 8;
  localparam int MAX_RES   = 7;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // host actions
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PROG  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DATA  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REPLY = 3'd4;

  // flash opcodes
  localparam logic [BYTE_W-1:0] OP_WREN  = 8'h06;
  localparam logic [BYTE_W-1:0] OP_RDSR  = 8'h05;
  localparam logic [BYTE_W-1:0] OP_READ  = 8'h03;
  localparam logic [BYTE_W-1:0] OP_PP    = 8'h02;
  localparam logic [BYTE_W-1:0] OP_SE    = 8'h20;
  localparam logic [BYTE_W-1:0] DUMMY    = 8'hFF;
  localparam int                BUSY_BIT = 0;

  typedef struct packed {
    logic              bus_valid;
    logic [BYTE_W-1:0] mosi_byte;
    logic              frame_end;
    logic              want_reply;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
    logic              data_ready;
    logic              done_res;
    logic              last;
  } res_t;

  function automatic res_t mk_byte(logic [BYTE_W-1:0] b, logic fe, logic wr, logic dr);
    res_t r;
    r            = '0;
    r.bus_valid  = 1'b1;
    r.mosi_byte  = b;
    r.frame_end  = fe;
    r.want_reply = wr;
    r.data_ready = dr;
    return r;
  endfunction

  function automatic res_t mk_read(logic [BYTE_W-1:0] d, logic dn);
    res_t r;
    r            = '0;
    r.read_valid = 1'b1;
    r.read_data  = d;
    r.done_res   = dn;
    return r;
  endfunction

  function automatic res_t mk_done();
    res_t r;
    r          = '0;
    r.done_res = 1'b1;
    return r;
  endfunction

endpackage

>>> hdl/snfs_in_if.sv
// snfs_in_if: request channel of the spi nor flash sequencer
// valid/ready handshake with the request fields; depends on snfs_pkg
interface snfs_in_if import snfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, action, address, length, data_byte, input ready);
  modport sink   (input valid, action, address, length, data_byte, output ready);
endinterface

>>> hdl/snfs_out_if.sv
// snfs_out_if: result channel of the spi nor flash sequencer
// valid/ready handshake with the per-byte result fields; depends on snfs_pkg
interface snfs_out_if import snfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              bus_valid;
  logic [BYTE_W-1:0] mosi_byte;
  logic              frame_end;
  logic              want_reply;
  logic              read_valid;
  logic [BYTE_W-1:0] read_data;
  logic              data_ready;
  logic              done_res;
  logic              last;

  modport source (output valid, bus_valid, mosi_byte, frame_end, want_reply, read_valid,
                  read_data, data_ready, done_res, last, input ready);
  modport sink   (input valid, bus_valid, mosi_byte, frame_end, want_reply, read_valid,
                  read_data, data_ready, done_res, last, output ready);
endinterface

>>> hdl/spi_nor_flash_sequencer.sv
// spi_nor_flash_sequencer: turns read, erase and program requests into spi nor byte frames
// depends on snfs_pkg, snfs_in_if and snfs_out_if

// Each accepted transaction (a start request, a program data byte or a byte received
// from the flash) is registered, then expanded into its list of up to seven result
// transactions, which the result buffer hands out one per cycle while out_ch.ready is
// high. The result count is seven for a sector erase step, five for a read or page
// chunk start and one to three otherwise; the next transaction is taken in the cycle
// its predecessor's last result leaves. Ignored transactions (busy block, data or
// reply not expected, undefined action) produce no results. Erase walks sectors of
// SECTOR_BYTES, program splits at PAGE_BYTES boundaries, both powers of two; addresses
// wrap within ADDRESS_BITS.
module spi_nor_flash_sequencer
  import snfs_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  snfs_in_if.sink    in_ch,
  snfs_out_if.source out_ch
);

  localparam int CL_W = $clog2(PAGE_BYTES + 1);
  localparam int PG_W = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {PH_IDLE, PH_READ, PH_EPOLL, PH_PDATA, PH_PPOLL} phase_t;
  typedef enum logic [3:0] {
    EM_NONE, EM_DONE, EM_RSTART, EM_ERASE, EM_CHUNK, EM_DATA, EM_POLL, EM_RMORE, EM_RLAST
  } emit_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  item_t                   item_r;
  logic                    item_vld_r;
  res_t                    res_r [MAX_RES];
  logic [RES_CNT_W-1:0]    res_cnt_r;
  phase_t                  phase_r, phase_nxt;
  logic [ADDRESS_BITS-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0]        rem_r, rem_nxt;
  logic [CL_W-1:0]         chunk_left_r, chunk_left_nxt;

  res_t                    lst [MAX_RES];
  logic [RES_CNT_W-1:0]    n_res;
  emit_t                   emit;
  logic                    load;
  logic                    in_hs, out_hs;

  logic [ADDRESS_BITS-1:0] addr_in;
  logic [LEN_W-1:0]        sec_off;
  logic [LEN_W:0]          span;
  logic [LEN_W-1:0]        span_sat;
  logic [ADDRESS_BITS-1:0] erase_base, sector_next, erase_addr, chunk_addr;
  logic [LEN_W-1:0]        chunk_rem;
  logic [CL_W-1:0]         room, chunk;
  logic [CL_W-1:0]         cl_dec;
  logic [ADDR_W-1:0]       ea, ca, ra;
  logic                    busy_bit;

  assign in_hs  = in_ch.valid && in_ch.ready;
  assign out_hs = out_ch.valid && out_ch.ready;
  assign load   = item_vld_r &&
                  ((res_cnt_r == '0) || ((res_cnt_r == RES_CNT_W'(1)) && out_ch.ready));
  assign in_ch.ready = !item_vld_r || load;

  // address arithmetic shared by the start and continuation paths
  assign addr_in     = item_r.address[ADDRESS_BITS-1:0];
  assign sec_off     = LEN_W'(addr_in) & LEN_W'(SECTOR_BYTES - 1);
  assign span        = {1'b0, sec_off} + {1'b0, item_r.length};
  assign span_sat    = span[LEN_W] ? '1 : span[LEN_W-1:0];
  assign erase_base  = addr_in & ~ADDRESS_BITS'(SECTOR_BYTES - 1);
  assign sector_next = cur_r + ADDRESS_BITS'(SECTOR_BYTES);
  assign busy_bit    = item_r.data_byte[BUSY_BIT];
  assign cl_dec      = (chunk_left_r != '0) ? chunk_left_r - CL_W'(1) : '0;

  // page chunk: start request uses the request fields, later chunks the running state
  always_comb begin
    if (phase_r == PH_IDLE) begin
      chunk_addr = addr_in;
      chunk_rem  = item_r.length;
    end else begin
      chunk_addr = cur_r;
      chunk_rem  = rem_r;
    end
    room  = CL_W'(PAGE_BYTES) - CL_W'(chunk_addr[PG_W-1:0]);
    chunk = (chunk_rem < LEN_W'(room)) ? chunk_rem[CL_W-1:0] : room;
  end

  // decide what the registered transaction does
  always_comb begin
    emit           = EM_NONE;
    phase_nxt      = phase_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    chunk_left_nxt = chunk_left_r;
    erase_addr     = erase_base;
    case (item_r.action)
      ACT_READ, ACT_ERASE, ACT_PROG: begin
        if (phase_r == PH_IDLE) begin
          if (item_r.length == '0) begin
            emit = EM_DONE;
          end else if (item_r.action == ACT_READ) begin
            emit      = EM_RSTART;
            cur_nxt   = addr_in;
            rem_nxt   = item_r.length - LEN_W'(1);
            phase_nxt = PH_READ;
          end else if (item_r.action == ACT_ERASE) begin
            emit      = EM_ERASE;
            cur_nxt   = erase_base;
            rem_nxt   = span_sat;
            phase_nxt = PH_EPOLL;
          end else begin
            emit           = EM_CHUNK;
            cur_nxt        = addr_in;
            rem_nxt        = item_r.length - LEN_W'(chunk);
            chunk_left_nxt = chunk;
            phase_nxt      = PH_PDATA;
          end
        end
      end
      ACT_DATA: begin
        if (phase_r == PH_PDATA) begin
          emit           = EM_DATA;
          chunk_left_nxt = cl_dec;
          cur_nxt        = cur_r + ADDRESS_BITS'(1);
          if (cl_dec == '0) phase_nxt = PH_PPOLL;
        end
      end
      ACT_REPLY: begin
        case (phase_r)
          PH_READ: begin
            if (rem_r != '0) begin
              emit    = EM_RMORE;
              rem_nxt = rem_r - LEN_W'(1);
            end else begin
              emit      = EM_RLAST;
              phase_nxt = PH_IDLE;
            end
          end
          PH_EPOLL: begin
            if (busy_bit) begin
              emit = EM_POLL;
            end else if (rem_r > LEN_W'(SECTOR_BYTES)) begin
              emit       = EM_ERASE;
              erase_addr = sector_next;
              rem_nxt    = rem_r - LEN_W'(SECTOR_BYTES);
              cur_nxt    = sector_next;
            end else begin
              emit      = EM_DONE;
              rem_nxt   = '0;
              phase_nxt = PH_IDLE;
            end
          end
          PH_PPOLL: begin
            if (busy_bit) begin
              emit = EM_POLL;
            end else if (rem_r != '0) begin
              emit           = EM_CHUNK;
              rem_nxt        = rem_r - LEN_W'(chunk);
              chunk_left_nxt = chunk;
              phase_nxt      = PH_PDATA;
            end else begin
              emit      = EM_DONE;
              phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // expand into the result list
  assign ea = ADDR_W'(erase_addr);
  assign ca = ADDR_W'(chunk_addr);
  assign ra = ADDR_W'(addr_in);

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) lst[i] = '0;
    n_res = '0;
    case (emit)
      EM_DONE: begin
        lst[0] = mk_done();
        n_res  = RES_CNT_W'(1);
      end
      EM_RSTART: begin
        lst[0] = mk_byte(OP_READ, 1'b0, 1'b0, 1'b0);
        lst[1] = mk_byte(ra[23:16], 1'b0, 1'b0, 1'b0);
        lst[2] = mk_byte(ra[15:8], 1'b0, 1'b0, 1'b0);
        lst[3] = mk_byte(ra[7:0], 1'b0, 1'b0, 1'b0);
        lst[4] = mk_byte(DUMMY, item_r.length == LEN_W'(1), 1'b1, 1'b0);
        n_res  = RES_CNT_W'(5);
      end
      EM_ERASE: begin
        lst[0] = mk_byte(OP_WREN, 1'b1, 1'b0, 1'b0);
        lst[1] = mk_byte(OP_SE, 1'b0, 1'b0, 1'b0);
        lst[2] = mk_byte(ea[23:16], 1'b0, 1'b0, 1'b0);
        lst[3] = mk_byte(ea[15:8], 1'b0, 1'b0, 1'b0);
        lst[4] = mk_byte(ea[7:0], 1'b1, 1'b0, 1'b0);
        lst[5] = mk_byte(OP_RDSR, 1'b0, 1'b0, 1'b0);
        lst[6] = mk_byte(DUMMY, 1'b1, 1'b1, 1'b0);
        n_res  = RES_CNT_W'(7);
      end
      EM_CHUNK: begin
        lst[0] = mk_byte(OP_WREN, 1'b1, 1'b0, 1'b0);
        lst[1] = mk_byte(OP_PP, 1'b0, 1'b0, 1'b0);
        lst[2] = mk_byte(ca[23:16], 1'b0, 1'b0, 1'b0);
        lst[3] = mk_byte(ca[15:8], 1'b0, 1'b0, 1'b0);
        lst[4] = mk_byte(ca[7:0], 1'b0, 1'b0, 1'b1);
        n_res  = RES_CNT_W'(5);
      end
      EM_DATA: begin
        lst[0] = mk_byte(item_r.data_byte, cl_dec == '0, 1'b0, cl_dec != '0);
        if (cl_dec == '0) begin
          lst[1] = mk_byte(OP_RDSR, 1'b0, 1'b0, 1'b0);
          lst[2] = mk_byte(DUMMY, 1'b1, 1'b1, 1'b0);
          n_res  = RES_CNT_W'(3);
        end else begin
          n_res  = RES_CNT_W'(1);
        end
      end
      EM_POLL: begin
        lst[0] = mk_byte(OP_RDSR, 1'b0, 1'b0, 1'b0);
        lst[1] = mk_byte(DUMMY, 1'b1, 1'b1, 1'b0);
        n_res  = RES_CNT_W'(2);
      end
      EM_RMORE: begin
        lst[0] = mk_read(item_r.data_byte, 1'b0);
        lst[1] = mk_byte(DUMMY, rem_r == LEN_W'(1), 1'b1, 1'b0);
        n_res  = RES_CNT_W'(2);
      end
      EM_RLAST: begin
        lst[0] = mk_read(item_r.data_byte, 1'b1);
        n_res  = RES_CNT_W'(1);
      end
      default: ;
    endcase
    for (int i = 0; i < MAX_RES; i++) begin
      if (n_res == RES_CNT_W'(i + 1)) lst[i].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r   <= 1'b0;
      res_cnt_r    <= '0;
      phase_r      <= PH_IDLE;
      cur_r        <= '0;
      rem_r        <= '0;
      chunk_left_r <= '0;
    end else begin
      if (in_hs) begin
        item_vld_r <= 1'b1;
        item_r     <= '{action: in_ch.action, address: in_ch.address,
                        length: in_ch.length, data_byte: in_ch.data_byte};
      end else if (load) begin
        item_vld_r <= 1'b0;
      end
      if (load) begin
        res_r        <= lst;
        res_cnt_r    <= n_res;
        phase_r      <= phase_nxt;
        cur_r        <= cur_nxt;
        rem_r        <= rem_nxt;
        chunk_left_r <= chunk_left_nxt;
      end else if (out_hs) begin
        // result buffer drains from the head
        for (int i = 0; i < MAX_RES - 1; i++) res_r[i] <= res_r[i+1];
        res_r[MAX_RES-1] <= '0;
        res_cnt_r        <= res_cnt_r - RES_CNT_W'(1);
      end
    end
  end

  assign out_ch.valid      = (res_cnt_r != '0);
  assign out_ch.bus_valid  = res_r[0].bus_valid;
  assign out_ch.mosi_byte  = res_r[0].mosi_byte;
  assign out_ch.frame_end  = res_r[0].frame_end;
  assign out_ch.want_reply = res_r[0].want_reply;
  assign out_ch.read_valid = res_r[0].read_valid;
  assign out_ch.read_data  = res_r[0].read_data;
  assign out_ch.data_ready = res_r[0].data_ready;
  assign out_ch.done_res   = res_r[0].done_res;
  assign out_ch.last       = res_r[0].last;

  // the head carries last exactly when it is the final result of its transaction
  a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == (res_cnt_r == RES_CNT_W'(1))))
    else $error("last flag does not match result buffer fill");

  // a page chunk in its data phase always expects at least one more byte
  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PDATA) |-> (chunk_left_r != '0))
    else $error("program data phase with empty chunk");

  // a stalled result buffer neither drains nor reloads
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(res_cnt_r))
    else $error("result buffer changed while stalled");

  // state advances only together with a new result list
  a_state_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(phase_r))
    else $error("phase changed without a transaction");

endmodule
